/* hdl/gsh_pkg.sv */
// Shared types, constants and coefficient helpers for the grid spline height block.
package gsh_pkg;

    localparam int VALUE_BITS      = 16;
    localparam int COORD_BITS      = 17;
    localparam int COORD_FRAC_BITS = 16;
    localparam int LOCAL_BITS      = COORD_FRAC_BITS;
    localparam int CFG_BITS        = 48;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int REG_COUNT       = 7;
    localparam int COEF_BITS       = 26;
    localparam int ACC_BITS        = 44;
    localparam int Q20_BITS        = 32;
    localparam int SQRT_IN_BITS    = 32;
    localparam int ROOT_BITS       = 16;
    localparam int SQRT_STAGES     = 8;
    localparam int CURVE_STAGES    = 4;

    localparam logic [COORD_BITS-1:0] COORD_ONE  = COORD_BITS'(1) << COORD_FRAC_BITS;
    localparam logic [COORD_BITS-1:0] COORD_HALF = COORD_BITS'(1) << (COORD_FRAC_BITS - 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HEIGHTS_ROW_FIRST  = 3'd0,
        REG_HEIGHTS_ROW_MIDDLE = 3'd1,
        REG_HEIGHTS_ROW_LAST   = 3'd2,
        REG_COL_SLOPES_START   = 3'd3,
        REG_COL_SLOPES_END     = 3'd4,
        REG_ROW_SLOPES_START   = 3'd5,
        REG_ROW_SLOPES_END     = 3'd6
    } cfg_reg_t;

    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic signed [COEF_BITS-1:0]  coef_val_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;

    typedef struct packed {
        val_t h0;
        val_t h1;
        val_t h2;
        val_t sa;
        val_t sb;
    } spline_t;

    typedef struct packed {
        coef_val_t k0;
        coef_val_t k1;
        coef_val_t k2;
        coef_val_t k3;
    } coef_t;

    function automatic val_t field_of(logic [CFG_BITS-1:0] r, int unsigned e);
        return val_t'(r[e*VALUE_BITS +: VALUE_BITS]);
    endfunction

    // Cubic coefficients of one piece, in units of the raw height LSB times four.
    function automatic coef_t spline_coef(spline_t s, logic upper);
        coef_t     c;
        coef_val_t h0;
        coef_val_t h1;
        coef_val_t h2;
        coef_val_t sa;
        coef_val_t sb;
        h0 = COEF_BITS'(s.h0);
        h1 = COEF_BITS'(s.h1);
        h2 = COEF_BITS'(s.h2);
        sa = COEF_BITS'(s.sa);
        sb = COEF_BITS'(s.sb);
        if (!upper) begin
            c.k0 = COEF_BITS'(4 * h0);
            c.k1 = COEF_BITS'(4 * sa);
            c.k2 = COEF_BITS'(-36 * h0 + 48 * h1 - 12 * h2 - 14 * sa + 2 * sb);
            c.k3 = COEF_BITS'(40 * h0 - 64 * h1 + 24 * h2 + 12 * sa - 4 * sb);
        end else begin
            c.k0 = COEF_BITS'(4 * h1);
            c.k1 = COEF_BITS'(-6 * h0 + 6 * h2 - sa - sb);
            c.k2 = COEF_BITS'(24 * h0 - 48 * h1 + 24 * h2 + 4 * sa - 4 * sb);
            c.k3 = COEF_BITS'(-24 * h0 + 64 * h1 - 40 * h2 - 4 * sa + 12 * sb);
        end
        return c;
    endfunction

endpackage

/* hdl/gsh_curve.sv */
// Four-stage pipelined Horner evaluation of one two-piece cubic spline.
module gsh_curve (
    input  logic                               aclk,
    input  logic                               en,
    input  gsh_pkg::spline_t                   spl,
    input  logic                               upper,
    input  logic [gsh_pkg::LOCAL_BITS-1:0]     u,
    output gsh_pkg::acc_t                      z
);

    localparam int SH   = gsh_pkg::COORD_FRAC_BITS;
    localparam int PW   = gsh_pkg::ACC_BITS + gsh_pkg::LOCAL_BITS + 1;
    localparam int P1W  = gsh_pkg::COEF_BITS + gsh_pkg::LOCAL_BITS + 1;

    gsh_pkg::coef_t c0_reg;
    logic [gsh_pkg::LOCAL_BITS-1:0] u0_reg, u1_reg, u2_reg;
    gsh_pkg::acc_t a1_reg, a2_reg, a3_reg;
    gsh_pkg::coef_val_t k1_1_reg, k0_1_reg, k0_2_reg;

    logic signed [P1W-1:0] p1;
    logic signed [PW-1:0]  p2, p3, r2, r3;
    gsh_pkg::acc_t a1_next, a2_next, a3_next;

    always_comb begin
        p1      = c0_reg.k3 * $signed({1'b0, u0_reg});
        a1_next = gsh_pkg::ACC_BITS'(p1) + (gsh_pkg::ACC_BITS'(c0_reg.k2) <<< SH);
        p2      = a1_reg * $signed({1'b0, u1_reg});
        r2      = (p2 + (PW'(1) <<< (SH - 1))) >>> SH;
        a2_next = gsh_pkg::ACC_BITS'(r2) + (gsh_pkg::ACC_BITS'(k1_1_reg) <<< SH);
        p3      = a2_reg * $signed({1'b0, u2_reg});
        r3      = (p3 + (PW'(1) <<< (SH - 1))) >>> SH;
        a3_next = gsh_pkg::ACC_BITS'(r3) + (gsh_pkg::ACC_BITS'(k0_2_reg) <<< SH);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c0_reg   <= gsh_pkg::spline_coef(spl, upper);
            u0_reg   <= u;
            a1_reg   <= a1_next;
            u1_reg   <= u0_reg;
            k1_1_reg <= c0_reg.k1;
            k0_1_reg <= c0_reg.k0;
            a2_reg   <= a2_next;
            u2_reg   <= u1_reg;
            k0_2_reg <= k0_1_reg;
            a3_reg   <= a3_next;
        end
    end

    assign z = a3_reg;

endmodule

/* hdl/gsh_sqrt.sv */
// Pipelined floor square root, two result bits per stage, with a saturation flag.
module gsh_sqrt (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [gsh_pkg::SQRT_IN_BITS-1:0]    n,
    input  logic                                sat,
    output logic [gsh_pkg::COORD_BITS-1:0]      height
);

    localparam int RW = gsh_pkg::ROOT_BITS + 4;
    localparam int NW = gsh_pkg::SQRT_IN_BITS;

    typedef struct packed {
        logic [RW-1:0]                    rem;
        logic [gsh_pkg::ROOT_BITS-1:0]    root;
        logic [NW-1:0]                    data;
        logic                             sat;
    } step_t;

    function automatic step_t sq_step(step_t a);
        step_t         o;
        logic [RW-1:0] r;
        logic [RW-1:0] trial;
        r      = {a.rem[RW-3:0], a.data[NW-1 -: 2]};
        trial  = {2'b00, a.root, 2'b01};
        o      = a;
        o.data = {a.data[NW-3:0], 2'b00};
        if (r >= trial) begin
            o.rem  = r - trial;
            o.root = {a.root[gsh_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {a.root[gsh_pkg::ROOT_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    step_t st_reg [gsh_pkg::SQRT_STAGES];
    step_t first;

    always_comb begin
        first.rem  = '0;
        first.root = '0;
        first.data = n;
        first.sat  = sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sq_step(sq_step(first));
            for (int i = 1; i < gsh_pkg::SQRT_STAGES; i++) begin
                st_reg[i] <= sq_step(sq_step(st_reg[i-1]));
            end
        end
    end

    assign height = st_reg[gsh_pkg::SQRT_STAGES-1].sat ? gsh_pkg::COORD_ONE
                  : {1'b0, st_reg[gsh_pkg::SQRT_STAGES-1].root};

endmodule

/* hdl/biquad_grid_spline_height.sv */
// Top level of the grid spline height surface: configuration, blending and pipeline control.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_coord_x, s_coord_y (Q1.16)
//  m_        out        m_valid / m_ready      m_height (Q1.16, 0 .. 1.0)
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (48 bits)
//
// One point enters per cycle while the output is not stalled; each point passes through
// the input register, the four-stage spline units, two blend stages, the product
// multiplier and the eight-stage square root. Reset is synchronous and active low; it
// clears the configuration registers and the valid bits. When the output is held by
// m_ready low, every stage holds together and s_ready drops, so no transfer is lost or
// repeated. Configuration writes are always taken and must arrive only while the
// pipeline is empty.
module biquad_grid_spline_height (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [gsh_pkg::COORD_BITS-1:0]       s_coord_x,
    input  logic [gsh_pkg::COORD_BITS-1:0]       s_coord_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gsh_pkg::COORD_BITS-1:0]       m_height,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gsh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gsh_pkg::CFG_BITS-1:0]         cfg_data
);

    // Input stage, spline units, two blend stages, product and square root.
    localparam int LAT      = 1 + gsh_pkg::CURVE_STAGES + 3 + gsh_pkg::SQRT_STAGES;
    localparam int CB       = gsh_pkg::COORD_BITS;
    localparam int LB       = gsh_pkg::LOCAL_BITS;
    localparam int SH       = gsh_pkg::COORD_FRAC_BITS;
    localparam int BW       = gsh_pkg::ACC_BITS + CB + 1;
    localparam int SW       = BW + 1;
    localparam int Q20_SH   = 10;

    logic [gsh_pkg::CFG_BITS-1:0] cfg_reg [gsh_pkg::REG_COUNT];
    logic [LAT-1:0]               vld_reg;
    logic                         adv;

    // The whole pipeline advances unless a finished height is waiting on the output.
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign m_valid   = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gsh_pkg::REG_COUNT; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_valid && (cfg_index < gsh_pkg::CFG_INDEX_BITS'(gsh_pkg::REG_COUNT))) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Column splines run along y through one grid column; row splines run along x.
    gsh_pkg::spline_t col_spl [3];
    gsh_pkg::spline_t row_spl [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            col_spl[i].h0 = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_HEIGHTS_ROW_FIRST], i);
            col_spl[i].h1 = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_HEIGHTS_ROW_MIDDLE], i);
            col_spl[i].h2 = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_HEIGHTS_ROW_LAST], i);
            col_spl[i].sa = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_COL_SLOPES_START], i);
            col_spl[i].sb = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_COL_SLOPES_END], i);
            row_spl[i].h0 = gsh_pkg::field_of(cfg_reg[i], 0);
            row_spl[i].h1 = gsh_pkg::field_of(cfg_reg[i], 1);
            row_spl[i].h2 = gsh_pkg::field_of(cfg_reg[i], 2);
            row_spl[i].sa = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_ROW_SLOPES_START], i);
            row_spl[i].sb = gsh_pkg::field_of(cfg_reg[gsh_pkg::REG_ROW_SLOPES_END], i);
        end
    end

    // Coordinates above 1.0 saturate; each then splits into a half select and a local offset.
    logic [CB-1:0] px, py;
    logic          x_upper, y_upper;
    logic [LB-1:0] lx, ly;

    always_comb begin
        px      = (s_coord_x > gsh_pkg::COORD_ONE) ? gsh_pkg::COORD_ONE : s_coord_x;
        py      = (s_coord_y > gsh_pkg::COORD_ONE) ? gsh_pkg::COORD_ONE : s_coord_y;
        x_upper = (px >= gsh_pkg::COORD_HALF);
        y_upper = (py >= gsh_pkg::COORD_HALF);
        lx      = x_upper ? LB'(px - gsh_pkg::COORD_HALF) : px[LB-1:0];
        ly      = y_upper ? LB'(py - gsh_pkg::COORD_HALF) : py[LB-1:0];
    end

    // Curves 0 and 1 are the column pair chosen by x, curves 2 and 3 the row pair by y.
    gsh_pkg::spline_t spl_reg   [4];
    logic             upper_reg [4];
    logic [LB-1:0]    u_reg     [4];
    logic [CB-1:0]    tx_reg    [gsh_pkg::CURVE_STAGES+1];
    logic [CB-1:0]    ty_reg    [gsh_pkg::CURVE_STAGES+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            spl_reg[0]   <= x_upper ? col_spl[1] : col_spl[0];
            spl_reg[1]   <= x_upper ? col_spl[2] : col_spl[1];
            spl_reg[2]   <= y_upper ? row_spl[1] : row_spl[0];
            spl_reg[3]   <= y_upper ? row_spl[2] : row_spl[1];
            upper_reg[0] <= y_upper;
            upper_reg[1] <= y_upper;
            upper_reg[2] <= x_upper;
            upper_reg[3] <= x_upper;
            u_reg[0]     <= ly;
            u_reg[1]     <= ly;
            u_reg[2]     <= lx;
            u_reg[3]     <= lx;
            tx_reg[0]    <= {lx, 1'b0};
            ty_reg[0]    <= {ly, 1'b0};
            for (int i = 1; i <= gsh_pkg::CURVE_STAGES; i++) begin
                tx_reg[i] <= tx_reg[i-1];
                ty_reg[i] <= ty_reg[i-1];
            end
        end
    end

    gsh_pkg::acc_t zc [4];

    for (genvar g = 0; g < 4; g++) begin : g_curve
        gsh_curve u_curve (
            .aclk  (aclk),
            .en    (adv),
            .spl   (spl_reg[g]),
            .upper (upper_reg[g]),
            .u     (u_reg[g]),
            .z     (zc[g])
        );
    end

    // Linear blend of the two curves of each pair: weights (1 - t) and t.
    logic signed [BW-1:0] bl_reg [4];
    logic [CB-1:0]        tx_w, ty_w;

    assign tx_w = tx_reg[gsh_pkg::CURVE_STAGES];
    assign ty_w = ty_reg[gsh_pkg::CURVE_STAGES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            bl_reg[0] <= zc[0] * $signed({1'b0, gsh_pkg::COORD_ONE - tx_w});
            bl_reg[1] <= zc[1] * $signed({1'b0, tx_w});
            bl_reg[2] <= zc[2] * $signed({1'b0, gsh_pkg::COORD_ONE - ty_w});
            bl_reg[3] <= zc[3] * $signed({1'b0, ty_w});
        end
    end

    // Round the blend, clamp negative estimates to zero and round to unsigned Q20, saturating on overflow.
    function automatic logic [gsh_pkg::Q20_BITS-1:0] to_q20(logic signed [SW-1:0] s);
        logic signed [SW-1:0] zr;
        logic [SW-1:0]        q;
        zr = (s + (SW'(1) <<< (SH - 1))) >>> SH;
        if (zr < 0) begin
            zr = '0;
        end
        q = (SW'(zr) + (SW'(1) << (Q20_SH - 1))) >> Q20_SH;
        return (|q[SW-1:gsh_pkg::Q20_BITS]) ? '1 : q[gsh_pkg::Q20_BITS-1:0];
    endfunction

    logic [gsh_pkg::Q20_BITS-1:0]   ex_reg, ey_reg;
    logic [2*gsh_pkg::Q20_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ex_reg   <= to_q20(SW'(bl_reg[0]) + SW'(bl_reg[1]));
            ey_reg   <= to_q20(SW'(bl_reg[2]) + SW'(bl_reg[3]));
            prod_reg <= ex_reg * ey_reg;
        end
    end

    // A product of 2^40 or more means a height of 1.0 or above, which saturates.
    gsh_sqrt u_sqrt (
        .aclk   (aclk),
        .en     (adv),
        .n      (prod_reg[gsh_pkg::SQRT_IN_BITS+7:8]),
        .sat    (|prod_reg[2*gsh_pkg::Q20_BITS-1:40]),
        .height (m_height)
    );

    // An accepted point always occupies the first stage on the next cycle.
    a_accept_fills : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted point did not enter the pipeline");

    // A stalled output freezes every stage's valid bit.
    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");

    // Heights never exceed 1.0.
    a_height_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_height <= gsh_pkg::COORD_ONE))
        else $error("height above 1.0");

endmodule
